FILE: hdl/hrp_pkg.sv
// Shared types, codes and constants of the HTTP response parser.
`timescale 1ns / 1ps
package hrp_pkg;

  localparam int unsigned LIMIT_W = 14;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;
  localparam logic [3:0] NAME_LEN = 4'd14;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_C = 8'h43;

  typedef enum logic [2:0] {
    PH_STATUS,
    PH_STATUS_CR,
    PH_FIELDS,
    PH_FIELDS_CR,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    STEP_VERSION,
    STEP_VERSION_MORE,
    STEP_CODE_FIRST,
    STEP_CODE,
    STEP_REASON_FIRST,
    STEP_REASON,
    STEP_BAD
  } status_step_t;

  typedef enum logic [1:0] {
    LEN_IDLE,
    LEN_SPACES,
    LEN_DIGITS
  } length_step_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_OVERSIZE,
    ERR_CR_NO_LF,
    ERR_STATUS_LINE,
    ERR_LENGTH_LINE
  } error_t;

  typedef struct packed {
    logic        has_byte;
    logic [7:0]  body_byte;
    logic        last;
    logic [15:0] status_code;
    logic [15:0] content_length;
    error_t      fault_code;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

FILE: hdl/hrp_if.sv
// Valid/ready channel interfaces for input bytes and parse results.
`timescale 1ns / 1ps
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [7:0] data_byte;

  modport source (output valid, output start_req, output data_byte, input ready);
  modport sink (input valid, input start_req, input data_byte, output ready);
endinterface

interface hrp_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  body_byte;
  logic        last;
  logic [15:0] status_code;
  logic [15:0] content_length;
  logic [2:0]  fault_code;

  modport source (output valid, output has_byte, output body_byte, output last,
                  output status_code, output content_length, output fault_code,
                  input ready);
  modport sink (input valid, input has_byte, input body_byte, input last,
                input status_code, input content_length, input fault_code,
                output ready);
endinterface

FILE: hdl/hrp_core.sv
// Per-byte parse state machine with the response limit register.
`timescale 1ns / 1ps
module hrp_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [hrp_pkg::LIMIT_W-1:0]    cfg_wr_data,
  hrp_in_if.sink                         byte_in,
  input  logic                           res_ready,
  output hrp_pkg::result_t               res
);
  import hrp_pkg::*;

  function automatic logic [15:0] sat_dec(input logic [15:0] v, input logic [7:0] c);
    logic [19:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, c[3:0]};
    return (t > 20'd65535) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_version(input logic [7:0] c);
    return c inside {"h", "H", "t", "T", "p", "P", "/", "1", "."};
  endfunction

  function automatic logic is_reason(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"z"], ["A":"Z"], " "};
  endfunction

  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd0:  r = "C";
      4'd1:  r = "o";
      4'd2:  r = "n";
      4'd3:  r = "t";
      4'd4:  r = "e";
      4'd5:  r = "n";
      4'd6:  r = "t";
      4'd7:  r = "-";
      4'd8:  r = "L";
      4'd9:  r = "e";
      4'd10: r = "n";
      4'd11: r = "g";
      4'd12: r = "t";
      4'd13: r = "h";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  logic [LIMIT_W-1:0] response_limit;

  phase_t             phase, phase_b, phase_next;
  status_step_t       status_step, status_step_b, status_step_next;
  logic [LIMIT_W-1:0] byte_count, byte_count_b, byte_count_next;
  logic [15:0]        status_value, status_value_b, status_value_next;
  logic               line_empty, line_empty_b, line_empty_next;
  logic [3:0]         name_match, name_match_b, name_match_next;
  logic               name_seen, name_seen_b, name_seen_next;
  length_step_t       length_step, length_step_b, length_step_next;
  logic [15:0]        digits_value, digits_value_b, digits_value_next;
  logic [15:0]        length_candidate, length_candidate_b, length_candidate_next;
  logic               candidate_valid, candidate_valid_b, candidate_valid_next;
  logic               line_has_lf, line_has_lf_b, line_has_lf_next;
  logic [15:0]        body_length, body_length_b, body_length_next;
  logic [15:0]        body_left, body_left_b, body_left_next;

  logic       acc;
  logic [7:0] c;
  logic       clr;
  logic       oversize;
  logic [3:0] nm_step;
  result_t    res_next;

  assign byte_in.ready = res_ready;
  assign acc = byte_in.valid && byte_in.ready;
  assign c = byte_in.data_byte;
  assign clr = byte_in.start_req;

  // start_req clears parse state before the byte is handled
  always_comb begin
    phase_b            = clr ? PH_STATUS : phase;
    status_step_b      = clr ? STEP_VERSION : status_step;
    byte_count_b       = clr ? '0 : byte_count;
    status_value_b     = clr ? '0 : status_value;
    line_empty_b       = clr ? 1'b1 : line_empty;
    name_match_b       = clr ? '0 : name_match;
    name_seen_b        = clr ? 1'b0 : name_seen;
    length_step_b      = clr ? LEN_IDLE : length_step;
    digits_value_b     = clr ? '0 : digits_value;
    length_candidate_b = clr ? '0 : length_candidate;
    candidate_valid_b  = clr ? 1'b0 : candidate_valid;
    line_has_lf_b      = clr ? 1'b0 : line_has_lf;
    body_length_b      = clr ? '0 : body_length;
    body_left_b        = clr ? '0 : body_left;
  end

  assign oversize = (byte_count_b >= response_limit);

  // next state
  always_comb begin
    phase_next            = phase_b;
    status_step_next      = status_step_b;
    byte_count_next       = byte_count_b;
    status_value_next     = status_value_b;
    line_empty_next       = line_empty_b;
    name_match_next       = name_match_b;
    name_seen_next        = name_seen_b;
    length_step_next      = length_step_b;
    digits_value_next     = digits_value_b;
    length_candidate_next = length_candidate_b;
    candidate_valid_next  = candidate_valid_b;
    line_has_lf_next      = line_has_lf_b;
    body_length_next      = body_length_b;
    body_left_next        = body_left_b;
    nm_step               = '0;
    if (phase_b != PH_DONE) begin
      if (oversize) begin
        phase_next = PH_DONE;
      end else begin
        byte_count_next = byte_count_b + 1'b1;
        case (phase_b)
          PH_STATUS: begin
            if (c == CHAR_CR) begin
              phase_next = PH_STATUS_CR;
            end else begin
              case (status_step_b)
                STEP_VERSION: begin
                  status_step_next = is_version(c) ? STEP_VERSION_MORE : STEP_BAD;
                end
                STEP_VERSION_MORE: begin
                  if (is_version(c)) status_step_next = STEP_VERSION_MORE;
                  else if (c == CHAR_SPACE) status_step_next = STEP_CODE_FIRST;
                  else status_step_next = STEP_BAD;
                end
                STEP_CODE_FIRST: begin
                  if (is_digit(c)) begin
                    status_value_next = sat_dec(status_value_b, c);
                    status_step_next  = STEP_CODE;
                  end else begin
                    status_step_next = STEP_BAD;
                  end
                end
                STEP_CODE: begin
                  if (is_digit(c)) status_value_next = sat_dec(status_value_b, c);
                  else if (c == CHAR_SPACE) status_step_next = STEP_REASON_FIRST;
                  else status_step_next = STEP_BAD;
                end
                STEP_REASON_FIRST, STEP_REASON: begin
                  status_step_next = is_reason(c) ? STEP_REASON : STEP_BAD;
                end
                default: status_step_next = STEP_BAD;
              endcase
            end
          end
          PH_STATUS_CR: begin
            if (c != CHAR_LF || status_step_b != STEP_REASON) begin
              phase_next = PH_DONE;
            end else begin
              phase_next            = PH_FIELDS;
              line_empty_next       = 1'b1;
              name_match_next       = '0;
              name_seen_next        = 1'b0;
              length_step_next      = LEN_IDLE;
              digits_value_next     = '0;
              length_candidate_next = '0;
              candidate_valid_next  = 1'b0;
              line_has_lf_next      = 1'b0;
            end
          end
          PH_FIELDS: begin
            if (c == CHAR_CR) begin
              if (length_step_b == LEN_DIGITS) begin
                length_candidate_next = digits_value_b;
                candidate_valid_next  = 1'b1;
                length_step_next      = LEN_IDLE;
              end
              phase_next = PH_FIELDS_CR;
            end else begin
              line_empty_next = 1'b0;
              if (c == CHAR_LF) line_has_lf_next = 1'b1;
              if (name_match_b < NAME_LEN && c == name_char(name_match_b)) begin
                nm_step = name_match_b + 1'b1;
              end else begin
                nm_step = (c == CHAR_UPPER_C) ? 4'd1 : 4'd0;
              end
              if (nm_step >= NAME_LEN) begin
                name_seen_next  = 1'b1;
                name_match_next = '0;
              end else begin
                name_match_next = nm_step;
              end
              if (length_step_b == LEN_DIGITS) begin
                if (is_digit(c)) begin
                  digits_value_next = sat_dec(digits_value_b, c);
                end else begin
                  length_candidate_next = digits_value_b;
                  candidate_valid_next  = 1'b1;
                  length_step_next      = (c == CHAR_COLON) ? LEN_SPACES : LEN_IDLE;
                end
              end else if (c == CHAR_COLON) begin
                length_step_next = LEN_SPACES;
              end else if (length_step_b == LEN_SPACES) begin
                if (is_digit(c)) begin
                  length_step_next  = LEN_DIGITS;
                  digits_value_next = sat_dec(16'd0, c);
                end else if (c != CHAR_SPACE) begin
                  length_step_next = LEN_IDLE;
                end
              end
            end
          end
          PH_FIELDS_CR: begin
            if (c != CHAR_LF) begin
              phase_next = PH_DONE;
            end else if (line_empty_b) begin
              if (body_length_b == 16'd0) begin
                phase_next = PH_DONE;
              end else begin
                body_left_next = body_length_b;
                phase_next     = PH_BODY;
              end
            end else if (name_seen_b && (line_has_lf_b || !candidate_valid_b)) begin
              phase_next = PH_DONE;
            end else begin
              if (name_seen_b) body_length_next = length_candidate_b;
              phase_next            = PH_FIELDS;
              line_empty_next       = 1'b1;
              name_match_next       = '0;
              name_seen_next        = 1'b0;
              length_step_next      = LEN_IDLE;
              digits_value_next     = '0;
              length_candidate_next = '0;
              candidate_valid_next  = 1'b0;
              line_has_lf_next      = 1'b0;
            end
          end
          PH_BODY: begin
            body_left_next = body_left_b - 1'b1;
            if (body_left_b == 16'd1) phase_next = PH_DONE;
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end
  end

  // result of this byte
  always_comb begin
    res_next                     = '0;
    res_next.item.status_code    = status_value_b;
    res_next.item.content_length = body_length_b;
    res_next.item.fault_code     = ERR_NONE;
    if (acc && phase_b != PH_DONE) begin
      if (oversize) begin
        res_next.valid           = 1'b1;
        res_next.item.last       = 1'b1;
        res_next.item.fault_code = ERR_OVERSIZE;
      end else begin
        case (phase_b)
          PH_STATUS_CR: begin
            if (c != CHAR_LF) begin
              res_next.valid           = 1'b1;
              res_next.item.last       = 1'b1;
              res_next.item.fault_code = ERR_CR_NO_LF;
            end else if (status_step_b != STEP_REASON) begin
              res_next.valid           = 1'b1;
              res_next.item.last       = 1'b1;
              res_next.item.fault_code = ERR_STATUS_LINE;
            end
          end
          PH_FIELDS_CR: begin
            if (c != CHAR_LF) begin
              res_next.valid           = 1'b1;
              res_next.item.last       = 1'b1;
              res_next.item.fault_code = ERR_CR_NO_LF;
            end else if (line_empty_b) begin
              if (body_length_b == 16'd0) begin
                res_next.valid     = 1'b1;
                res_next.item.last = 1'b1;
              end
            end else if (name_seen_b && (line_has_lf_b || !candidate_valid_b)) begin
              res_next.valid           = 1'b1;
              res_next.item.last       = 1'b1;
              res_next.item.fault_code = ERR_LENGTH_LINE;
            end
          end
          PH_BODY: begin
            res_next.valid          = 1'b1;
            res_next.item.has_byte  = 1'b1;
            res_next.item.body_byte = c;
            res_next.item.last      = (body_left_b == 16'd1);
          end
          default: res_next.valid = 1'b0;
        endcase
      end
    end
  end

  assign res = res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      response_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      response_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_STATUS;
      status_step      <= STEP_VERSION;
      byte_count       <= '0;
      status_value     <= '0;
      line_empty       <= 1'b1;
      name_match       <= '0;
      name_seen        <= 1'b0;
      length_step      <= LEN_IDLE;
      digits_value     <= '0;
      length_candidate <= '0;
      candidate_valid  <= 1'b0;
      line_has_lf      <= 1'b0;
      body_length      <= '0;
      body_left        <= '0;
    end else if (acc) begin
      phase            <= phase_next;
      status_step      <= status_step_next;
      byte_count       <= byte_count_next;
      status_value     <= status_value_next;
      line_empty       <= line_empty_next;
      name_match       <= name_match_next;
      name_seen        <= name_seen_next;
      length_step      <= length_step_next;
      digits_value     <= digits_value_next;
      length_candidate <= length_candidate_next;
      candidate_valid  <= candidate_valid_next;
      line_has_lf      <= line_has_lf_next;
      body_length      <= body_length_next;
      body_left        <= body_left_next;
    end
  end

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE && !(acc && byte_in.start_req) |=> phase == PH_DONE)
    else $error("parser left completion without a new response");

  a_result_ends: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.item.last |=> phase == PH_DONE)
    else $error("final result did not close the response");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.item.fault_code != ERR_NONE |-> res.item.last && !res.item.has_byte)
    else $error("error result carries a body byte or lacks last");

endmodule

FILE: hdl/hrp_skid.sv
// Output register with a skid stage for parse results.
`timescale 1ns / 1ps
module hrp_skid (
  input  logic             clk,
  input  logic             rst,
  input  hrp_pkg::result_t res,
  output logic             res_ready,
  hrp_out_if.source        result_out
);
  import hrp_pkg::*;

  logic      m_valid;
  out_item_t m_data;
  logic      s_valid;
  out_item_t s_data;
  logic      pop;

  assign pop = m_valid && result_out.ready;
  assign res_ready = !s_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (pop) begin
      if (s_valid) begin
        m_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        m_valid <= res.valid;
      end
    end else if (res.valid) begin
      if (!m_valid) m_valid <= 1'b1;
      else s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (s_valid) m_data <= s_data;
      else if (res.valid) m_data <= res.item;
    end else if (res.valid) begin
      if (!m_valid) m_data <= res.item;
      else s_data <= res.item;
    end
  end

  assign result_out.valid          = m_valid;
  assign result_out.has_byte       = m_data.has_byte;
  assign result_out.body_byte      = m_data.body_byte;
  assign result_out.last           = m_data.last;
  assign result_out.status_code    = m_data.status_code;
  assign result_out.content_length = m_data.content_length;
  assign result_out.fault_code     = m_data.fault_code;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !s_valid)
    else $error("result pushed into a full buffer");

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    s_valid |-> m_valid)
    else $error("skid entry held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    s_valid && result_out.ready |=> m_valid && !s_valid)
    else $error("skid entry not moved on pop");

endmodule

FILE: hdl/http_response_parser_unit.sv
// Top level of the HTTP response parser: byte channel in, result channel out.
//
//   channel      dir  handshake      payload
//   byte_in      in   valid/ready    start_req, data_byte
//   result_out   out  valid/ready    has_byte, body_byte, last, status_code,
//                                    content_length, fault_code
//   cfg          in   cfg_wr_en      cfg_wr_data (response_limit)
//
// One byte is taken per cycle while the skid entry is empty; any result that
// the parse logic in hrp_core gives feeds a registered two-entry output buffer.
// Synchronous reset sets response_limit to 8192 and clears all parse state.
// While result_out stalls, bytes keep flowing until the skid entry fills.
`timescale 1ns / 1ps
module http_response_parser_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [hrp_pkg::LIMIT_W-1:0] cfg_wr_data,
  hrp_in_if.sink                      byte_in,
  hrp_out_if.source                   result_out
);
  import hrp_pkg::*;

  result_t res;
  logic    res_ready;

  hrp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_in     (byte_in),
    .res_ready   (res_ready),
    .res         (res)
  );

  hrp_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .res_ready  (res_ready),
    .result_out (result_out)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the HTTP response parser: directed and random byte streams.
`timescale 1ns / 1ps
module testbench;
  import hrp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam logic [8*14-1:0] LENGTH_NAME = "Content-Length";
  localparam string VERSION_SET = "hHtTpP/1.";
  localparam string REASON_SET = "abzAMZ09 x";
  localparam string WORD_SET = "abcdefgXYZ-";

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKED} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [LIMIT_W-1:0] cfg_wr_data;

  hrp_in_if byte_ch ();
  hrp_out_if result_ch ();

  http_response_parser_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .byte_in    (byte_ch),
    .result_out (result_ch)
  );

  always #1 clk = ~clk;

  // parser state as the block should hold it
  phase_t             ph;
  status_step_t       st_step;
  int unsigned        byte_total;
  logic [15:0]        status_val;
  logic               line_blank;
  int unsigned        name_pos;
  logic               name_hit;
  length_step_t       len_step;
  logic [15:0]        digit_acc;
  logic [15:0]        len_cand;
  logic               cand_ok;
  logic               lf_in_line;
  logic [15:0]        body_len;
  logic [15:0]        body_rem;
  logic [LIMIT_W-1:0] limit_reg;

  out_item_t   response_results[$];
  out_item_t   got_want;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_mode_left = 0;
  logic [1:0]  rx_tick = 2'd0;

  function automatic logic [15:0] dec_accum(logic [15:0] v, logic [7:0] c);
    int unsigned t;
    t = int'(v) * 10 + int'(c) - 48;
    return (t > 65535) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_reason(logic [7:0] c);
    return is_digit(c) || c == CHAR_SPACE || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void clear_line();
    line_blank = 1'b1;
    name_pos = 0;
    name_hit = 1'b0;
    len_step = LEN_IDLE;
    digit_acc = '0;
    len_cand = '0;
    cand_ok = 1'b0;
    lf_in_line = 1'b0;
  endfunction

  function automatic void clear_response();
    ph = PH_STATUS;
    st_step = STEP_VERSION;
    byte_total = 0;
    status_val = '0;
    body_len = '0;
    body_rem = '0;
    clear_line();
  endfunction

  function automatic void push_result(logic has, logic [7:0] b, logic lst, error_t err);
    out_item_t r;
    r.has_byte = has;
    r.body_byte = b;
    r.last = lst;
    r.status_code = status_val;
    r.content_length = body_len;
    r.fault_code = err;
    response_results.push_back(r);
  endfunction

  function automatic void end_response(error_t err);
    ph = PH_DONE;
    push_result(1'b0, 8'd0, 1'b1, err);
  endfunction

  function automatic void status_char(logic [7:0] c);
    logic ver;
    ver = c inside {"h", "H", "t", "T", "p", "P", "/", "1", "."};
    case (st_step)
      STEP_VERSION: st_step = ver ? STEP_VERSION_MORE : STEP_BAD;
      STEP_VERSION_MORE: begin
        if (ver) st_step = STEP_VERSION_MORE;
        else st_step = (c == CHAR_SPACE) ? STEP_CODE_FIRST : STEP_BAD;
      end
      STEP_CODE_FIRST: begin
        if (is_digit(c)) begin
          status_val = dec_accum(status_val, c);
          st_step = STEP_CODE;
        end else st_step = STEP_BAD;
      end
      STEP_CODE: begin
        if (is_digit(c)) status_val = dec_accum(status_val, c);
        else st_step = (c == CHAR_SPACE) ? STEP_REASON_FIRST : STEP_BAD;
      end
      STEP_REASON_FIRST, STEP_REASON: st_step = is_reason(c) ? STEP_REASON : STEP_BAD;
      default: st_step = STEP_BAD;
    endcase
  endfunction

  function automatic void field_char(logic [7:0] c);
    line_blank = 1'b0;
    if (c == CHAR_LF) lf_in_line = 1'b1;
    if (name_pos < NAME_LEN && c == LENGTH_NAME[8*(13-name_pos) +: 8]) name_pos++;
    else name_pos = (c == CHAR_UPPER_C) ? 1 : 0;
    if (name_pos >= NAME_LEN) begin
      name_hit = 1'b1;
      name_pos = 0;
    end
    if (len_step == LEN_DIGITS) begin
      if (is_digit(c)) digit_acc = dec_accum(digit_acc, c);
      else begin
        len_cand = digit_acc;
        cand_ok = 1'b1;
        len_step = (c == CHAR_COLON) ? LEN_SPACES : LEN_IDLE;
      end
    end else if (c == CHAR_COLON) begin
      len_step = LEN_SPACES;
    end else if (len_step == LEN_SPACES) begin
      if (is_digit(c)) begin
        len_step = LEN_DIGITS;
        digit_acc = dec_accum(16'd0, c);
      end else if (c != CHAR_SPACE) len_step = LEN_IDLE;
    end
  endfunction

  function automatic void track_response_byte(logic start, logic [7:0] c);
    if (start) clear_response();
    if (ph == PH_DONE) return;
    if (byte_total >= limit_reg) begin
      end_response(ERR_OVERSIZE);
      return;
    end
    byte_total++;
    case (ph)
      PH_STATUS: begin
        if (c == CHAR_CR) ph = PH_STATUS_CR;
        else status_char(c);
      end
      PH_STATUS_CR: begin
        if (c != CHAR_LF) end_response(ERR_CR_NO_LF);
        else if (st_step != STEP_REASON) end_response(ERR_STATUS_LINE);
        else begin
          ph = PH_FIELDS;
          clear_line();
        end
      end
      PH_FIELDS: begin
        if (c == CHAR_CR) begin
          if (len_step == LEN_DIGITS) begin
            len_cand = digit_acc;
            cand_ok = 1'b1;
            len_step = LEN_IDLE;
          end
          ph = PH_FIELDS_CR;
        end else field_char(c);
      end
      PH_FIELDS_CR: begin
        if (c != CHAR_LF) end_response(ERR_CR_NO_LF);
        else if (line_blank) begin
          if (body_len == 16'd0) begin
            ph = PH_DONE;
            push_result(1'b0, 8'd0, 1'b1, ERR_NONE);
          end else begin
            body_rem = body_len;
            ph = PH_BODY;
          end
        end else if (name_hit && (lf_in_line || !cand_ok)) begin
          end_response(ERR_LENGTH_LINE);
        end else begin
          if (name_hit) body_len = len_cand;
          clear_line();
          ph = PH_FIELDS;
        end
      end
      PH_BODY: begin
        body_rem--;
        if (body_rem == 16'd0) ph = PH_DONE;
        push_result(1'b1, c, body_rem == 16'd0, ERR_NONE);
      end
      default: ph = PH_DONE;
    endcase
  endfunction

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (response_results.size() == 0) begin
        $error("result with none pending: has_byte %0d last %0d fault_code %0d",
               result_ch.has_byte, result_ch.last, result_ch.fault_code);
        fail_count++;
      end else begin
        got_want = response_results.pop_front();
        check_field("has_byte", 16'(got_want.has_byte), 16'(result_ch.has_byte));
        check_field("body_byte", 16'(got_want.body_byte), 16'(result_ch.body_byte));
        check_field("last", 16'(got_want.last), 16'(result_ch.last));
        check_field("status_code", got_want.status_code, result_ch.status_code);
        check_field("content_length", got_want.content_length, result_ch.content_length);
        check_field("fault_code", 16'(got_want.fault_code), 16'(result_ch.fault_code));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk) begin
    rx_tick <= rx_tick + 2'd1;
    if (rx_mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_mode_left <= $urandom_range(20, 200);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   result_ch.ready <= 1'b1;
      RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: result_ch.ready <= (rx_tick == 2'd0);
      default:   result_ch.ready <= ($urandom_range(0, 19) == 0);
    endcase
  end

  task automatic send_byte(input logic start, input logic [7:0] b);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    byte_ch.valid <= 1'b1;
    byte_ch.start_req <= start;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    track_response_byte(start, b);
    bytes_sent++;
  endtask

  task automatic send_stream(ref logic [7:0] msg[$]);
    foreach (msg[i]) send_byte(i == 0, msg[i]);
  endtask

  task automatic settle_block();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (response_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_response_limit(input logic [LIMIT_W-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    limit_reg = value;
  endtask

  function automatic void add_text(ref logic [7:0] q[$], input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void add_crlf(ref logic [7:0] q[$]);
    q.push_back(CHAR_CR);
    q.push_back(CHAR_LF);
  endfunction

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic int unsigned pick_length();
    case ($urandom_range(0, 19))
      0:       return $urandom_range(65530, 99999);
      1, 2:    return $urandom_range(13, 300);
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic void build_response(ref logic [7:0] q[$]);
    int unsigned len_val;
    int unsigned n;
    int unsigned cut;
    len_val = 0;
    repeat ($urandom_range(1, 4)) q.push_back(pick_char(VERSION_SET));
    q.push_back(CHAR_SPACE);
    if ($urandom_range(0, 9) == 0) add_text(q, $sformatf("%0d", $urandom_range(65530, 999999)));
    else add_text(q, $sformatf("%0d", $urandom_range(0, 599)));
    q.push_back(CHAR_SPACE);
    repeat ($urandom_range(1, 6)) q.push_back(pick_char(REASON_SET));
    add_crlf(q);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0, 1: begin
          add_text(q, "X-");
          repeat ($urandom_range(1, 5)) q.push_back(pick_char(WORD_SET));
          add_text(q, ":");
          repeat ($urandom_range(0, 2)) q.push_back(CHAR_SPACE);
          repeat ($urandom_range(1, 4)) q.push_back(pick_char(REASON_SET));
          if ($urandom_range(0, 7) == 0) begin
            q.push_back(CHAR_LF);
            q.push_back(pick_char(WORD_SET));
          end
        end
        2, 3: begin
          if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) != 0) add_text(q, "C");
            else add_text(q, "X-");
          end
          add_text(q, "Content-Length");
          n = pick_length();
          case ($urandom_range(0, 9))
            0: add_text(q, ": none");
            1: begin
              add_text(q, $sformatf(":\n%0d", n));
              len_val = n;
            end
            2: begin
              add_text(q, $sformatf(": 7 :%0d", n));
              len_val = n;
            end
            3: begin
              add_text(q, $sformatf(":%0d; q:", n));
              len_val = n;
            end
            default: begin
              add_text(q, ":");
              repeat ($urandom_range(0, 2)) q.push_back(CHAR_SPACE);
              add_text(q, $sformatf("%0d", n));
              len_val = n;
            end
          endcase
        end
        4: repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
        default: add_text(q, $sformatf("Content-Len: %0d", $urandom_range(0, 9)));
      endcase
      add_crlf(q);
    end
    add_crlf(q);
    repeat ((len_val > 40) ? $urandom_range(0, 40) : len_val)
      q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0) begin
      cut = $urandom_range(1, q.size());
      while (q.size() > cut) void'(q.pop_back());
    end
  endfunction

  task automatic run_traffic(input int unsigned budget);
    logic [7:0] msg[$];
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      msg.delete();
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 4))
          send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        build_response(msg);
        send_stream(msg);
      end
    end
  endtask

  task automatic test_status_line();
    logic [7:0] msg[$];
    add_text(msg, "h 0 z");
    add_crlf(msg);
    add_crlf(msg);
    send_stream(msg);
    msg.delete();
    add_text(msg, "P1. 99999 Ok 9");
    add_crlf(msg);
    add_crlf(msg);
    send_stream(msg);
    send_byte(1'b0, "Q");
  endtask

  task automatic test_body_delivery();
    logic [7:0] msg[$];
    add_text(msg, "T 2 B");
    add_crlf(msg);
    add_text(msg, "Content-Length: 2");
    add_crlf(msg);
    add_crlf(msg);
    msg.push_back(8'hFF);
    msg.push_back(8'h00);
    send_stream(msg);
    msg.delete();
    add_text(msg, "H 1 A");
    add_crlf(msg);
    add_text(msg, "a\nb");
    add_crlf(msg);
    add_text(msg, "Content-Length: 5 x:1");
    add_crlf(msg);
    add_crlf(msg);
    msg.push_back(8'h80);
    send_stream(msg);
  endtask

  task automatic test_line_errors();
    logic [7:0] msg[$];
    add_text(msg, "H");
    msg.push_back(CHAR_CR);
    add_text(msg, "X");
    send_stream(msg);
    msg.delete();
    add_text(msg, "H 1 A");
    add_crlf(msg);
    add_text(msg, "x");
    msg.push_back(CHAR_CR);
    add_text(msg, "Y");
    send_stream(msg);
    msg.delete();
    add_text(msg, "H 1");
    add_crlf(msg);
    send_stream(msg);
    msg.delete();
    add_text(msg, "H 1 A");
    add_crlf(msg);
    add_text(msg, "Content-Length");
    add_crlf(msg);
    send_stream(msg);
    msg.delete();
    add_text(msg, "H 1 A");
    add_crlf(msg);
    add_text(msg, "Content-Length:\n4");
    add_crlf(msg);
    send_stream(msg);
  endtask

  task automatic test_oversize();
    logic [7:0] msg[$];
    write_response_limit(14'd1);
    add_text(msg, "HH");
    send_stream(msg);
    write_response_limit(14'd16383);
    msg.delete();
    add_text(msg, "H 204 N");
    add_crlf(msg);
    add_crlf(msg);
    send_stream(msg);
  endtask

  task automatic test_random_traffic();
    int unsigned limits[6];
    int unsigned budgets[6] = '{230, 180, 30, 150, 150, 110};
    limits = '{LIMIT_RESET, 16383, 1, $urandom_range(20, 80), $urandom_range(100, 400),
               $urandom_range(1, 16383)};
    foreach (limits[i]) begin
      write_response_limit(limits[i][LIMIT_W-1:0]);
      run_traffic(budgets[i]);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.start_req = 1'b0;
    byte_ch.data_byte = 8'd0;
    limit_reg = LIMIT_RESET;
    clear_response();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_status_line();
    test_body_delivery();
    test_line_errors();
    test_oversize();
    test_random_traffic();
    settle_block();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/hrp_pkg.sv
hdl/hrp_if.sv
hdl/hrp_core.sv
hdl/hrp_skid.sv
hdl/http_response_parser_unit.sv
tb/testbench.sv
